/* src/awsp_pkg.sv */
// Shared types and constants for the adaptive window sequential prefetch unit.
// No dependencies; imported by awsp_agen, awsp_seq and the top level.
`timescale 1ns / 1ps
`default_nettype none

package awsp_pkg;

	localparam int ADDR_W      = 32;
	localparam int TGT_W       = ADDR_W + 1;	// exact sum, carry kept
	localparam int WIN_W       = 5;
	localparam int AHEAD_W     = 16;
	localparam int SHIFT_W     = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 40;

	localparam int WIN_LIMIT_DEF = 16;

	localparam logic [WIN_W-1:0]   USEFUL_MAX      = 5'd31;
	localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 4'd6;
	localparam logic [ADDR_W-1:0]  MAX_ADDRESS_RST = 32'hFFFF_FFFF;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ADDRESS = 1'b1;

	// action codes
	localparam logic ACT_CLEAR = 1'b0;
	localparam logic ACT_TAG   = 1'b1;

	// sequencer -> address unit
	typedef struct packed {
		logic load;
		logic advance;
	} agen_ctl_t;

endpackage : awsp_pkg

`default_nettype wire

/* src/awsp_agen.sv */
// Shared block address unit: one 33-bit adder and one compare against max_address.
// Depends on awsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module awsp_agen (
	input  wire                             clk,
	input  wire awsp_pkg::agen_ctl_t        ctl,
	input  wire  [awsp_pkg::ADDR_W-1:0]     base_addr,
	input  wire  [awsp_pkg::SHIFT_W-1:0]    block_shift,
	input  wire  [awsp_pkg::ADDR_W-1:0]     max_address,
	output logic [awsp_pkg::TGT_W-1:0]      target,
	output logic                            in_range
);
	import awsp_pkg::*;

	logic [TGT_W-1:0] stride;
	logic [TGT_W-1:0] add_a;
	logic [TGT_W-1:0] target_q;

	assign stride = TGT_W'(1) << block_shift;
	// load starts at one block ahead, advance steps one more block
	assign add_a  = ctl.load ? {1'b0, base_addr} : target_q;

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.advance) begin
			target_q <= add_a + stride;
		end
	end

	assign target   = target_q;
	assign in_range = (target_q <= {1'b0, max_address});

endmodule : awsp_agen

`default_nettype wire

/* src/awsp_seq.sv */
// Sequencer: window adaptation state, result stepping and the output word register.
// Depends on awsp_pkg; drives awsp_agen through agen_ctl_t.
`timescale 1ns / 1ps
`default_nettype none

module awsp_seq #(
	parameter int WIN_LIMIT = awsp_pkg::WIN_LIMIT_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// accepted access
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [awsp_pkg::ADDR_W-1:0]     access_address,
	input  wire                             miss,
	input  wire                             was_prefetched,
	input  wire  [awsp_pkg::AHEAD_W-1:0]    cached_ahead,
	// address unit
	output awsp_pkg::agen_ctl_t             agen_ctl,
	input  wire  [awsp_pkg::TGT_W-1:0]      target,
	input  wire                             in_range,
	// result word
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            action,
	output logic [awsp_pkg::ADDR_W-1:0]     block_address,
	output logic                            pf_issue,
	output logic                            last
);
	import awsp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CLEAR = 3'b010,
		ST_TAG   = 3'b100
	} state_t;

	state_t             state_q;
	logic [WIN_W-1:0]   win_q;
	logic [WIN_W-1:0]   thr_q;
	logic               lock_q;
	logic [WIN_W-1:0]   left_q;
	logic [WIN_W-1:0]   useful_q;
	logic               start_q;
	logic [WIN_W-1:0]   cnt_q;
	logic [AHEAD_W-1:0] cached_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               ovalid_q;
	logic               oact_q;
	logic [ADDR_W-1:0]  oaddr_q;
	logic               opf_q;
	logic               olast_q;

	logic               accept;
	logic               slot_free;
	logic               word_load;
	logic               clear_in;
	logic               start;
	logic               shrink;
	logic [WIN_W-1:0]   useful_inc;
	logic [WIN_W-1:0]   win_dec;
	logic [WIN_W-1:0]   win_inc;
	logic [WIN_W-1:0]   win_n;
	logic [WIN_W-1:0]   thr_n;
	logic               lock_n;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !ovalid_q || out_ready;
	assign word_load = ((state_q == ST_CLEAR) || (state_q == ST_TAG)) && slot_free;
	assign clear_in  = !miss && was_prefetched;
	assign start     = (left_q == '0);

	assign useful_inc = (clear_in && useful_q != USEFUL_MAX) ?
		useful_q + WIN_W'(1) : useful_q;
	assign shrink     = (useful_inc < thr_q) && (win_q >= WIN_W'(2));
	assign win_dec    = win_q - WIN_W'(1);
	assign win_inc    = (win_q < WIN_W'(WIN_LIMIT)) ? win_q + WIN_W'(1) : win_q;

	always_comb begin
		win_n  = win_q;
		thr_n  = thr_q;
		lock_n = lock_q;
		if (shrink) begin
			win_n  = win_dec;
			lock_n = 1'b1;
			thr_n  = (win_dec >= WIN_W'(3)) ? win_dec - WIN_W'(1) : WIN_W'(1);
		end else if (lock_q) begin
			lock_n = 1'b0;
		end else begin
			win_n = win_inc;
			thr_n = win_inc - WIN_W'(1);
		end
	end

	assign agen_ctl.load    = accept;
	assign agen_ctl.advance = (state_q == ST_TAG) && slot_free;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			win_q    <= WIN_W'(1);
			thr_q    <= WIN_W'(1);
			lock_q   <= 1'b0;
			left_q   <= '0;
			useful_q <= '0;
			start_q  <= 1'b0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (word_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_q <= start;
						if (start) begin
							win_q    <= win_n;
							thr_q    <= thr_n;
							lock_q   <= lock_n;
							left_q   <= win_n;
							cnt_q    <= win_n;
							useful_q <= '0;
						end else begin
							left_q   <= left_q - WIN_W'(1);
							useful_q <= useful_inc;
						end
						if (clear_in) begin
							state_q <= ST_CLEAR;
						end else if (start) begin
							state_q <= ST_TAG;
						end
					end
				end
				ST_CLEAR: begin
					if (slot_free) begin
						state_q <= start_q ? ST_TAG : ST_IDLE;
					end
				end
				ST_TAG: begin
					if (slot_free) begin
						cnt_q <= cnt_q - WIN_W'(1);
						if (cnt_q == WIN_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= access_address;
			cached_q <= cached_ahead;
		end
		if ((state_q == ST_CLEAR) && slot_free) begin
			oact_q  <= ACT_CLEAR;
			oaddr_q <= addr_q;
			opf_q   <= 1'b0;
			olast_q <= !start_q;
		end
		if ((state_q == ST_TAG) && slot_free) begin
			oact_q   <= ACT_TAG;
			oaddr_q  <= target[ADDR_W-1:0];
			opf_q    <= in_range && !cached_q[0];
			olast_q  <= (cnt_q == WIN_W'(1));
			cached_q <= cached_q >> 1;
		end
	end

	assign out_valid     = ovalid_q;
	assign action        = oact_q;
	assign block_address = oaddr_q;
	assign pf_issue      = opf_q;
	assign last          = olast_q;

endmodule : awsp_seq

`default_nettype wire

/* src/adaptive_window_sequential_prefetch_unit.sv */
// Top level of the adaptive window sequential prefetch unit: config registers and stream ports.
// Depends on awsp_pkg, awsp_agen and awsp_seq.
//
//   channel   dir   handshake              payload
//   s_*       in    s_tvalid / s_tready    s_tdata: one demand access
//   m_*       out   m_tvalid / m_tready    m_tdata, m_tuser, m_tlast: one action
//   cfg_*     in    cfg_we                 cfg_index, cfg_data
//
// An access causes n result words (n = 0 .. WIN_LIMIT + 1): it is first accepted and the
// window adapted, then the words follow, the single block address adder stepping one
// block per cycle while the output word register is free to take a word.
// s_tready is high only while the sequencer is idle; the output word register lets the
// next access be taken while the last word still waits on m_tready.
// Reset: window 1, threshold 1, block_shift 6, max_address all ones, no word pending.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_window_sequential_prefetch_unit #(
	parameter int WIN_LIMIT = awsp_pkg::WIN_LIMIT_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// [31:0] access_address, [32] miss, [33] was_prefetched, [49:34] cached_ahead
	input  wire  [awsp_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// [31:0] block_address, [32] pf_issue
	output logic [awsp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] action
	output logic                               m_tuser,
	output logic                               m_tlast,
	input  wire                                cfg_we,
	input  wire  [awsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [awsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import awsp_pkg::*;

	logic [SHIFT_W-1:0] block_shift_q;
	logic [ADDR_W-1:0]  max_address_q;

	agen_ctl_t          agen_ctl;
	logic [TGT_W-1:0]   target;
	logic               in_range;
	logic [ADDR_W-1:0]  block_address;
	logic               pf_issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_shift_q <= BLOCK_SHIFT_RST;
			max_address_q <= MAX_ADDRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_SHIFT: block_shift_q <= cfg_data[SHIFT_W-1:0];
				REG_MAX_ADDRESS: max_address_q <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	awsp_agen u_agen (
		.clk         (clk),
		.ctl         (agen_ctl),
		.base_addr   (s_tdata[ADDR_W-1:0]),
		.block_shift (block_shift_q),
		.max_address (max_address_q),
		.target      (target),
		.in_range    (in_range)
	);

	awsp_seq #(
		.WIN_LIMIT (WIN_LIMIT)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.access_address (s_tdata[ADDR_W-1:0]),
		.miss           (s_tdata[ADDR_W]),
		.was_prefetched (s_tdata[ADDR_W+1]),
		.cached_ahead   (s_tdata[ADDR_W+2+AHEAD_W-1:ADDR_W+2]),
		.agen_ctl       (agen_ctl),
		.target         (target),
		.in_range       (in_range),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.action         (m_tuser),
		.block_address  (block_address),
		.pf_issue       (pf_issue),
		.last           (m_tlast)
	);

	assign m_tdata = {(OUT_TDATA_W-ADDR_W-1)'(0), pf_issue, block_address};

endmodule : adaptive_window_sequential_prefetch_unit

`default_nettype wire
